// ===== rtl/sct_pkg.sv =====
// Package for the sector chain table engine.
// Holds the operation codes, status codes, table constants and the memory request type.
// No dependencies.
`timescale 1ns / 1ps

package sct_pkg;

	localparam int SECTORS   = 256;
	localparam int TBL_DEPTH = 256;
	localparam int TBL_AW    = 8;
	localparam int TBL_DW    = 8;

	localparam logic [TBL_DW-1:0] EMPTY     = 8'hFF;
	localparam logic [TBL_DW-1:0] LAST_SLOT = 8'd254;
	localparam logic [TBL_DW-1:0] MAX_COUNT = 8'd255;
	// Free sectors at or above this bound collide with the table image sector.
	localparam logic [TBL_DW:0]   FS_LIMIT  = 9'(SECTORS - 1);

	typedef enum logic [2:0] {
		OP_NEW_FILE = 3'd0,
		OP_APPEND   = 3'd1,
		OP_SIZE     = 3'd2,
		OP_LOCATE   = 3'd3,
		OP_FORMAT   = 3'd4,
		OP_LOAD     = 3'd5,
		OP_DUMP     = 3'd6
	} op_t;

	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_CORRUPT = 2'd2;

	typedef struct packed {
		logic              we;
		logic [TBL_AW-1:0] waddr;
		logic [TBL_DW-1:0] wdata;
		logic [TBL_AW-1:0] raddr;
	} mem_req_t;

endpackage

// ===== rtl/sct_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port with registered data.
// No dependencies.
`timescale 1ns / 1ps

module sct_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256,
	parameter int AW    = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/sct_ctrl.sv =====
// Operation sequencer of the sector chain table engine.
// Drives the directory and link memories and forms one result per operation; uses sct_pkg.
`timescale 1ns / 1ps

module sct_ctrl (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [2:0]                    operation,
	input  logic [7:0]                    file_number,
	input  logic [7:0]                    location,
	input  logic [8:0]                    table_index,
	input  logic [7:0]                    table_byte,
	output logic                          done,
	output logic [1:0]                    status,
	output logic [7:0]                    value,
	output sct_pkg::mem_req_t             dir_req,
	output sct_pkg::mem_req_t             link_req,
	input  logic [sct_pkg::TBL_DW-1:0]    dir_rdata,
	input  logic [sct_pkg::TBL_DW-1:0]    link_rdata
);
	import sct_pkg::*;

	typedef enum logic [3:0] {
		S_CLEAR,
		S_IDLE,
		S_NEW_CHK,
		S_APP_SLOT,
		S_WALK,
		S_APP_START,
		S_APP_WRITE,
		S_SIZE_START,
		S_SIZE_WALK,
		S_LOC_START,
		S_LOC_WALK,
		S_DUMP_OUT
	} state_t;

	state_t            state_q;
	op_t               op_in;
	logic [TBL_AW-1:0] clr_q;
	logic              fmt_q;
	logic [7:0]        num_q;
	logic [7:0]        loc_q;
	logic              dump_link_q;
	logic [7:0]        slot_q;
	logic [7:0]        cur_q;
	logic [7:0]        cnt_q;
	logic [7:0]        next_q;
	logic [7:0]        fs_q;
	logic              phase_b_q;
	logic              start_empty_q;
	logic              done_q;
	logic [1:0]        status_q;
	logic [7:0]        value_q;
	logic              fs_fits;
	logic [7:0]        last_plus;

	assign op_in     = op_t'(operation);
	assign busy      = (state_q != S_IDLE);
	assign done      = done_q;
	assign status    = status_q;
	assign value     = value_q;
	assign fs_fits   = ({1'b0, fs_q} < FS_LIMIT);
	// A walked sector is never the end marker, so one past it still fits in a byte.
	assign last_plus = cur_q + 8'd1;

	always_comb begin
		dir_req        = '0;
		link_req       = '0;
		dir_req.raddr  = num_q;
		link_req.raddr = cur_q;
		unique case (state_q)
			S_CLEAR: begin
				dir_req.we     = 1'b1;
				dir_req.waddr  = clr_q;
				dir_req.wdata  = EMPTY;
				link_req.we    = 1'b1;
				link_req.waddr = clr_q;
				link_req.wdata = EMPTY;
			end
			S_IDLE: begin
				link_req.raddr = table_index[7:0];
				if (op_in == OP_NEW_FILE || op_in == OP_APPEND) begin
					dir_req.raddr = '0;
				end else if (op_in == OP_DUMP) begin
					dir_req.raddr = table_index[7:0];
				end else begin
					dir_req.raddr = file_number;
				end
				if (start && op_in == OP_LOAD) begin
					if (table_index[8]) begin
						link_req.we    = 1'b1;
						link_req.waddr = table_index[7:0];
						link_req.wdata = table_byte;
					end else begin
						dir_req.we    = 1'b1;
						dir_req.waddr = table_index[7:0];
						dir_req.wdata = table_byte;
					end
				end
			end
			S_NEW_CHK: begin
				dir_req.raddr = slot_q + 8'd1;
			end
			S_APP_SLOT: begin
				dir_req.raddr  = num_q;
				link_req.raddr = dir_rdata;
			end
			S_WALK: begin
				if (link_rdata == EMPTY) begin
					dir_req.raddr = slot_q + 8'd1;
				end else begin
					link_req.raddr = link_rdata;
				end
			end
			S_APP_START, S_SIZE_START, S_LOC_START: begin
				link_req.raddr = dir_rdata;
			end
			S_APP_WRITE: begin
				if (fs_fits) begin
					if (start_empty_q) begin
						dir_req.we    = 1'b1;
						dir_req.waddr = num_q;
						dir_req.wdata = fs_q;
					end else begin
						link_req.we    = 1'b1;
						link_req.waddr = cur_q;
						link_req.wdata = fs_q;
					end
				end
			end
			S_SIZE_WALK, S_LOC_WALK: begin
				link_req.raddr = link_rdata;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= S_CLEAR;
			clr_q         <= '0;
			fmt_q         <= 1'b0;
			num_q         <= '0;
			loc_q         <= '0;
			dump_link_q   <= 1'b0;
			slot_q        <= '0;
			cur_q         <= '0;
			cnt_q         <= '0;
			next_q        <= '0;
			fs_q          <= '0;
			phase_b_q     <= 1'b0;
			start_empty_q <= 1'b0;
			done_q        <= 1'b0;
			status_q      <= ST_OK;
			value_q       <= '0;
		end else begin
			done_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + TBL_AW'(1);
					if (clr_q == TBL_AW'(TBL_DEPTH - 1)) begin
						state_q <= S_IDLE;
						if (fmt_q) begin
							done_q   <= 1'b1;
							status_q <= ST_OK;
							value_q  <= '0;
						end
					end
				end
				S_IDLE: begin
					if (start) begin
						num_q       <= file_number;
						loc_q       <= location;
						dump_link_q <= table_index[8];
						unique case (op_in)
							OP_NEW_FILE: begin
								slot_q  <= '0;
								state_q <= S_NEW_CHK;
							end
							OP_APPEND: begin
								slot_q  <= '0;
								next_q  <= '0;
								state_q <= S_APP_SLOT;
							end
							OP_SIZE:   state_q <= S_SIZE_START;
							OP_LOCATE: state_q <= S_LOC_START;
							OP_FORMAT: begin
								clr_q   <= '0;
								fmt_q   <= 1'b1;
								state_q <= S_CLEAR;
							end
							OP_LOAD: begin
								done_q   <= 1'b1;
								status_q <= ST_OK;
								value_q  <= '0;
							end
							OP_DUMP:   state_q <= S_DUMP_OUT;
							default: begin
								done_q   <= 1'b1;
								status_q <= ST_FULL;
								value_q  <= '0;
							end
						endcase
					end
				end
				S_NEW_CHK: begin
					if (dir_rdata == EMPTY) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						value_q  <= slot_q;
						state_q  <= S_IDLE;
					end else if (slot_q == LAST_SLOT) begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						value_q  <= EMPTY;
						state_q  <= S_IDLE;
					end else begin
						slot_q <= slot_q + 8'd1;
					end
				end
				S_APP_SLOT: begin
					if (dir_rdata == EMPTY) begin
						fs_q    <= next_q;
						state_q <= S_APP_START;
					end else begin
						cur_q     <= dir_rdata;
						cnt_q     <= '0;
						phase_b_q <= 1'b0;
						state_q   <= S_WALK;
					end
				end
				S_WALK: begin
					if (link_rdata == EMPTY) begin
						// cur_q is the last sector of the chain.
						if (phase_b_q) begin
							state_q <= S_APP_WRITE;
						end else begin
							if (last_plus > next_q) begin
								next_q <= last_plus;
							end
							if (slot_q == MAX_COUNT) begin
								done_q   <= 1'b1;
								status_q <= ST_CORRUPT;
								value_q  <= EMPTY;
								state_q  <= S_IDLE;
							end else begin
								slot_q  <= slot_q + 8'd1;
								state_q <= S_APP_SLOT;
							end
						end
					end else if (cnt_q == MAX_COUNT) begin
						done_q   <= 1'b1;
						status_q <= ST_CORRUPT;
						value_q  <= EMPTY;
						state_q  <= S_IDLE;
					end else begin
						cur_q <= link_rdata;
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_APP_START: begin
					if (dir_rdata == EMPTY) begin
						start_empty_q <= 1'b1;
						state_q       <= S_APP_WRITE;
					end else begin
						start_empty_q <= 1'b0;
						cur_q         <= dir_rdata;
						cnt_q         <= '0;
						phase_b_q     <= 1'b1;
						state_q       <= S_WALK;
					end
				end
				S_APP_WRITE: begin
					done_q  <= 1'b1;
					state_q <= S_IDLE;
					if (fs_fits) begin
						status_q <= ST_OK;
						value_q  <= fs_q;
					end else begin
						status_q <= ST_FULL;
						value_q  <= EMPTY;
					end
				end
				S_SIZE_START: begin
					if (dir_rdata == EMPTY) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						value_q  <= '0;
						state_q  <= S_IDLE;
					end else begin
						cnt_q   <= 8'd1;
						state_q <= S_SIZE_WALK;
					end
				end
				S_SIZE_WALK: begin
					if (link_rdata == EMPTY || cnt_q == MAX_COUNT) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						value_q  <= cnt_q;
						state_q  <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_LOC_START: begin
					if (dir_rdata == EMPTY) begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						value_q  <= EMPTY;
						state_q  <= S_IDLE;
					end else if (loc_q == '0) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						value_q  <= dir_rdata;
						state_q  <= S_IDLE;
					end else begin
						cnt_q   <= 8'd1;
						state_q <= S_LOC_WALK;
					end
				end
				S_LOC_WALK: begin
					if (link_rdata == EMPTY) begin
						done_q   <= 1'b1;
						status_q <= ST_FULL;
						value_q  <= EMPTY;
						state_q  <= S_IDLE;
					end else if (cnt_q == loc_q) begin
						done_q   <= 1'b1;
						status_q <= ST_OK;
						value_q  <= link_rdata;
						state_q  <= S_IDLE;
					end else begin
						cnt_q <= cnt_q + 8'd1;
					end
				end
				S_DUMP_OUT: begin
					done_q   <= 1'b1;
					status_q <= ST_OK;
					value_q  <= dump_link_q ? link_rdata : dir_rdata;
					state_q  <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule

// ===== rtl/sector_chain_table_engine.sv =====
// Top level of the sector chain table engine: directory memory, link memory and sequencer.
// Depends on sct_pkg, sct_ram and sct_ctrl.
//
//   channel   | handshake          | payload
//   ----------+--------------------+--------------------------------------------------
//   command   | start / busy       | operation, file_number, location, table_index,
//             |                    | table_byte
//   result    | done (one cycle)   | status, value
//
// A command transfer happens when start is high and busy is low; each command yields
// exactly one result, shown for the single cycle in which done is high.
// Load writes and dump reads one table entry; format reruns the clearing pass; new file
// makes one directory read a cycle; size follows every sector of the chain, locate follows
// links up to the location, and append scans directory slots and walks every chain found,
// the target chain included.
// Each memory has a single read port: every step of a walk is one read.
// After reset a clearing pass fills both tables with 255; busy is high.
// The receiver cannot stall; results are never held back.
`timescale 1ns / 1ps

module sector_chain_table_engine (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [2:0] operation,
	input  logic [7:0] file_number,
	input  logic [7:0] location,
	input  logic [8:0] table_index,
	input  logic [7:0] table_byte,
	output logic       done,
	output logic [1:0] status,
	output logic [7:0] value
);
	import sct_pkg::*;

	mem_req_t          dir_req;
	mem_req_t          link_req;
	logic [TBL_DW-1:0] dir_rdata;
	logic [TBL_DW-1:0] link_rdata;

	sct_ram #(
		.WIDTH (TBL_DW),
		.DEPTH (TBL_DEPTH)
	) u_dir_ram (
		.clk   (clk),
		.we    (dir_req.we),
		.waddr (dir_req.waddr),
		.wdata (dir_req.wdata),
		.raddr (dir_req.raddr),
		.rdata (dir_rdata)
	);

	sct_ram #(
		.WIDTH (TBL_DW),
		.DEPTH (TBL_DEPTH)
	) u_link_ram (
		.clk   (clk),
		.we    (link_req.we),
		.waddr (link_req.waddr),
		.wdata (link_req.wdata),
		.raddr (link_req.raddr),
		.rdata (link_rdata)
	);

	sct_ctrl u_ctrl (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.operation   (operation),
		.file_number (file_number),
		.location    (location),
		.table_index (table_index),
		.table_byte  (table_byte),
		.done        (done),
		.status      (status),
		.value       (value),
		.dir_req     (dir_req),
		.link_req    (link_req),
		.dir_rdata   (dir_rdata),
		.link_rdata  (link_rdata)
	);

endmodule

// ===== rtl/sct_checker.sv =====
// Port-level checker for the sector chain table engine, bound to the top level.
// Depends on sct_pkg.
`timescale 1ns / 1ps

module sct_checker (
	input logic       clk,
	input logic       arst_n,
	input logic       start,
	input logic       busy,
	input logic [2:0] operation,
	input logic [7:0] file_number,
	input logic [7:0] location,
	input logic [8:0] table_index,
	input logic [7:0] table_byte,
	input logic       done,
	input logic [1:0] status,
	input logic [7:0] value
);
	import sct_pkg::*;

	// A result always closes the command, so the engine is free when it shows one.
	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while engine still busy");

	a_load_result: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && operation == OP_LOAD) |=> (done && status == ST_OK && value == '0))
		else $error("load did not complete in one cycle with success");

	a_multi_cycle_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy && (operation == OP_NEW_FILE || operation == OP_APPEND ||
			operation == OP_SIZE || operation == OP_LOCATE ||
			operation == OP_FORMAT || operation == OP_DUMP)) |=> (busy && !done))
		else $error("table operation did not hold the engine busy");

	a_corrupt_value: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_CORRUPT) |-> value == EMPTY)
		else $error("corrupt chain result without end marker value");

	a_status_code: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (status == ST_OK || status == ST_FULL || status == ST_CORRUPT))
		else $error("undefined status code on result");

endmodule

bind sector_chain_table_engine sct_checker u_sct_checker (.*);
